@@ hdl/bitrd_pkg.sv @@
package bitrd_pkg;

    // default sizing
    localparam int DEF_BUFFER_BYTES = 4096;
    localparam int DEF_READ_WIDTH   = 32;

    // fixed field widths
    localparam int BYTE_W   = 8;
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_SKIP    = 2'd2;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // one result word
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]  bits_done;
        logic [COUNT_W-1:0]  bits_remaining;
        logic [STATUS_W-1:0] status;
    } res_t;

endpackage

@@ hdl/bitrd_ram.sv @@
module bitrd_ram #(
    parameter int DEPTH = bitrd_pkg::DEF_BUFFER_BYTES
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(DEPTH)-1:0]          waddr,
    input  logic [bitrd_pkg::BYTE_W-1:0]      wdata,
    input  logic                              re,
    input  logic [$clog2(DEPTH)-1:0]          raddr,
    output logic [bitrd_pkg::BYTE_W-1:0]      rdata
);
    import bitrd_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/bitrd_ctrl.sv @@
module bitrd_ctrl #(
    parameter int BUFFER_BYTES = bitrd_pkg::DEF_BUFFER_BYTES,
    parameter int READ_WIDTH   = bitrd_pkg::DEF_READ_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [bitrd_pkg::OP_W-1:0]          opcode,
    input  logic [bitrd_pkg::BYTE_W-1:0]        data_byte,
    input  logic [bitrd_pkg::COUNT_W-1:0]       bit_count,
    output logic                                busy,
    output logic                                res_valid,
    output bitrd_pkg::res_t                     res,
    output logic                                mem_we,
    output logic [$clog2(BUFFER_BYTES)-1:0]     mem_waddr,
    output logic [bitrd_pkg::BYTE_W-1:0]        mem_wdata,
    output logic                                mem_re,
    output logic [$clog2(BUFFER_BYTES)-1:0]     mem_raddr,
    input  logic [bitrd_pkg::BYTE_W-1:0]        mem_rdata
);
    import bitrd_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
    localparam int BIT_W  = $clog2(BUFFER_BYTES * BYTE_W + 1);
    localparam int CMP_W  = (BIT_W > COUNT_W) ? BIT_W : COUNT_W;
    localparam int RD_W   = $clog2(READ_WIDTH + 1);
    localparam int SPAN_W = RD_W + 1;
    localparam int MAXB   = (READ_WIDTH + 14) / BYTE_W;
    localparam int NB_W   = $clog2(MAXB + 1);
    localparam int ACC_W  = MAXB * BYTE_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_WAIT  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       bytes_loaded_reg, bytes_loaded_next;
    logic [BIT_W-1:0]       pos_reg, pos_next;
    logic [BIT_W-1:0]       avail_reg, avail_next;
    logic [ADDR_W-1:0]      idx_reg, idx_next;
    logic [NB_W-1:0]        issue_left_reg, issue_left_next;
    logic                   rvalid_reg, rvalid_next;
    logic                   first_reg, first_next;
    logic [2:0]             off_reg, off_next;
    logic [2:0]             tail_reg, tail_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [RD_W-1:0]        done_reg, done_next;
    logic                   short_reg, short_next;

    logic                   accept;
    logic [COUNT_W-1:0]     want_rd;
    logic [COUNT_W-1:0]     want;
    logic [CMP_W-1:0]       want_ext;
    logic [CMP_W-1:0]       avail_ext;
    logic [CMP_W-1:0]       take;
    logic                   short_now;
    logic [RD_W-1:0]        rd_take;
    logic [SPAN_W-1:0]      span;
    logic [BYTE_W-1:0]      first_mask;
    logic [BYTE_W-1:0]      in_byte;
    logic [ACC_W-1:0]       shifted;
    logic [ACC_W+VALUE_W-1:0] value_wide;
    logic [BIT_W+COUNT_W-1:0] avail_wide;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // length of this item, reads saturated to the read width, clipped to the unread bits
    assign want_rd   = (bit_count > COUNT_W'(READ_WIDTH)) ? COUNT_W'(READ_WIDTH) : bit_count;
    assign want      = (opcode == OP_READ) ? want_rd : bit_count;
    assign want_ext  = CMP_W'(want);
    assign avail_ext = CMP_W'(avail_reg);
    assign take      = (want_ext < avail_ext) ? want_ext : avail_ext;
    assign short_now = (take != want_ext);
    assign rd_take   = take[RD_W-1:0];
    assign span      = SPAN_W'(pos_reg[2:0]) + SPAN_W'(rd_take) + SPAN_W'(7);

    // incoming byte, leading bits of the first byte cleared
    assign first_mask = {BYTE_W{1'b1}} >> off_reg;
    assign in_byte    = first_reg ? (mem_rdata & first_mask) : mem_rdata;

    // alignment of the gathered bits
    assign shifted    = acc_next >> tail_reg;
    assign value_wide = {{VALUE_W{1'b0}}, shifted};
    assign avail_wide = {{COUNT_W{1'b0}}, avail_next};

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        bytes_loaded_next = bytes_loaded_reg;
        pos_next          = pos_reg;
        avail_next        = avail_reg;
        idx_next          = idx_reg;
        issue_left_next   = issue_left_reg;
        rvalid_next       = 1'b0;
        first_next        = first_reg;
        off_next          = off_reg;
        tail_next         = tail_reg;
        acc_next          = acc_reg;
        done_next         = done_reg;
        short_next        = short_reg;
        mem_we            = 1'b0;
        mem_waddr         = bytes_loaded_reg[ADDR_W-1:0];
        mem_wdata         = data_byte;
        mem_re            = 1'b0;
        mem_raddr         = idx_reg;
        res_valid         = 1'b0;
        res.value         = '0;
        res.bits_done     = '0;
        res.status        = ST_OK;

        // gather returning bytes
        if (rvalid_reg)
        begin
            acc_next   = {acc_reg[ACC_W-BYTE_W-1:0], in_byte};
            first_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_LOAD:
                        begin
                            res_valid = 1'b1;
                            if (bytes_loaded_reg < CNT_W'(BUFFER_BYTES))
                            begin
                                mem_we            = 1'b1;
                                bytes_loaded_next = bytes_loaded_reg + CNT_W'(1);
                                avail_next        = avail_reg + BIT_W'(BYTE_W);
                            end
                            else
                            begin
                                res.status = ST_FULL;
                            end
                        end
                        OP_READ:
                        begin
                            pos_next   = pos_reg + take[BIT_W-1:0];
                            avail_next = avail_reg - take[BIT_W-1:0];
                            if (take == '0)
                            begin
                                res_valid  = 1'b1;
                                res.status = short_now ? ST_SHORT : ST_OK;
                            end
                            else
                            begin
                                state_next      = S_FETCH;
                                idx_next        = pos_reg[ADDR_W+2:3];
                                issue_left_next = NB_W'(span >> 3);
                                first_next      = 1'b1;
                                off_next        = pos_reg[2:0];
                                tail_next       = 3'd0 - pos_reg[2:0] - rd_take[2:0];
                                acc_next        = '0;
                                done_next       = rd_take;
                                short_next      = short_now;
                            end
                        end
                        OP_SKIP:
                        begin
                            pos_next      = pos_reg + take[BIT_W-1:0];
                            avail_next    = avail_reg - take[BIT_W-1:0];
                            res_valid     = 1'b1;
                            res.bits_done = take[COUNT_W-1:0];
                            res.status    = short_now ? ST_SHORT : ST_OK;
                        end
                        OP_RESTART:
                        begin
                            bytes_loaded_next = '0;
                            pos_next          = '0;
                            avail_next        = '0;
                            res_valid         = 1'b1;
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                mem_re          = 1'b1;
                rvalid_next     = 1'b1;
                idx_next        = idx_reg + ADDR_W'(1);
                issue_left_next = issue_left_reg - NB_W'(1);
                if (issue_left_reg == NB_W'(1))
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                // last byte lands here
                res_valid     = 1'b1;
                res.value     = value_wide[VALUE_W-1:0];
                res.bits_done = COUNT_W'(done_reg);
                res.status    = short_reg ? ST_SHORT : ST_OK;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.bits_remaining = avail_wide[COUNT_W-1:0];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            bytes_loaded_reg <= '0;
            pos_reg          <= '0;
            avail_reg        <= '0;
            issue_left_reg   <= '0;
            rvalid_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            bytes_loaded_reg <= bytes_loaded_next;
            pos_reg          <= pos_next;
            avail_reg        <= avail_next;
            issue_left_reg   <= issue_left_next;
            rvalid_reg       <= rvalid_next;
        end
    end

    // per-read working registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        first_reg <= first_next;
        off_reg   <= off_next;
        tail_reg  <= tail_next;
        acc_reg   <= acc_next;
        done_reg  <= done_next;
        short_reg <= short_next;
    end

    // unread count tracks loaded bits less read position
    a_avail_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (BIT_W + 1)'(avail_reg) + (BIT_W + 1)'(pos_reg)
            == (BIT_W + 1)'({bytes_loaded_reg, 3'b000}))
        else $error("unread count out of step with load count and position");

    // load count never passes the buffer size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_loaded_reg <= CNT_W'(BUFFER_BYTES))
        else $error("load count beyond buffer size");

    // writes and reads of the store never meet
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("store written and read in one cycle");

    // the final byte is always returning when waiting
    a_wait_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |-> rvalid_reg)
        else $error("waiting for a byte that was never requested");

    // a read result frees the block the next cycle
    a_wait_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |=> (state_reg == S_IDLE))
        else $error("read did not finish after its last byte");

endmodule

@@ hdl/msb_first_bit_reader_top.sv @@
// MSB-first bit reader over a byte buffer held in a single-port-read RAM.
// Command channel: a word (opcode, data_byte, bit_count) is taken at a rising
// edge with start high and busy low. Opcodes: load byte, read bits, skip
// bits, restart. Each word gives exactly one result word on value,
// bits_done, bits_remaining and status, marked by valid for one cycle.
// Load, skip, restart and reads that take no bits: valid rises the cycle
// after the command, busy stays low, a new command can follow at once.
// Read of k bits starting at bit offset o in a byte touches
// n = ceil((o + k) / 8) bytes, 1 to 5 for reads of up to 32 bits: busy is
// high while the n bytes are fetched and the last one lands, valid rises
// after that; the next command is taken once busy is low. The read time is
// set by the buffer RAM's one byte-wide read port, one byte per cycle.
// Reset empties the buffer and clears the read position; the RAM contents
// are not cleared, as only bytes loaded since are ever read.
// The receiver cannot stall: a result is marked by valid for its one cycle only.
module msb_first_bit_reader_top #(
    parameter int BUFFER_BYTES = bitrd_pkg::DEF_BUFFER_BYTES,
    parameter int READ_WIDTH   = bitrd_pkg::DEF_READ_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bitrd_pkg::OP_W-1:0]        opcode,
    input  logic [bitrd_pkg::BYTE_W-1:0]      data_byte,
    input  logic [bitrd_pkg::COUNT_W-1:0]     bit_count,
    output logic                              valid,
    output logic [bitrd_pkg::VALUE_W-1:0]     value,
    output logic [bitrd_pkg::COUNT_W-1:0]     bits_done,
    output logic [bitrd_pkg::COUNT_W-1:0]     bits_remaining,
    output logic [bitrd_pkg::STATUS_W-1:0]    status
);
    import bitrd_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_BYTES);

    logic                res_valid;
    res_t                res;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [BYTE_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [BYTE_W-1:0]   mem_rdata;
    logic                valid_reg;
    res_t                res_reg;

    // byte buffer
    bitrd_ram #(
        .DEPTH (BUFFER_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // command sequencer
    bitrd_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .READ_WIDTH   (READ_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (opcode),
        .data_byte (data_byte),
        .bit_count (bit_count),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= res_valid;
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign valid          = valid_reg;
    assign value          = res_reg.value;
    assign bits_done      = res_reg.bits_done;
    assign bits_remaining = res_reg.bits_remaining;
    assign status         = res_reg.status;

endmodule

@@ bench/tb_msb_first_bit_reader_top.sv @@
module tb_msb_first_bit_reader_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bitrd_pkg::*;

    localparam int BUFFER_BYTES = DEF_BUFFER_BYTES;
    localparam int READ_WIDTH   = DEF_READ_WIDTH;
    localparam int RANDOM_WORDS = 1300;
    localparam int STALL_LIMIT  = 1000;

    // mirror of the bit reader: byte store, fill level and read position
    class bitstream_scoreboard;
        logic [BYTE_W-1:0] stream_bytes [BUFFER_BYTES];
        int unsigned       bytes_held;
        int unsigned       bit_pos;
        res_t              expected_results [$];
        int unsigned       mismatches;

        function new();
            bytes_held = 0;
            bit_pos    = 0;
            mismatches = 0;
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // apply one accepted word to the mirror and queue its result
        function void predict_command(input logic [OP_W-1:0] op,
                                      input logic [BYTE_W-1:0] din,
                                      input logic [COUNT_W-1:0] count);
            res_t        r;
            int unsigned avail;
            int unsigned want;
            int unsigned done;
            int unsigned p;
            r     = '0;
            done  = 0;
            avail = bytes_held * 8 - bit_pos;
            case (op)
                OP_LOAD:
                begin
                    if (bytes_held < BUFFER_BYTES)
                    begin
                        stream_bytes[bytes_held] = din;
                        bytes_held++;
                    end
                    else
                    begin
                        r.status = ST_FULL;
                    end
                end
                OP_READ:
                begin
                    // counts above the read width saturate
                    want = (count > READ_WIDTH) ? READ_WIDTH : count;
                    done = (want < avail) ? want : avail;
                    if (done < want)
                        r.status = ST_SHORT;
                    for (int i = 0; i < done; i++)
                    begin
                        p = bit_pos + i;
                        r.value = {r.value[VALUE_W-2:0], stream_bytes[p >> 3][7 - (p & 7)]};
                    end
                    bit_pos += done;
                end
                OP_SKIP:
                begin
                    done = (count < avail) ? count : avail;
                    if (done < count)
                        r.status = ST_SHORT;
                    bit_pos += done;
                end
                default:
                begin
                    bytes_held = 0;
                    bit_pos    = 0;
                end
            endcase
            r.bits_done      = COUNT_W'(done);
            r.bits_remaining = COUNT_W'(bytes_held * 8 - bit_pos);
            expected_results.push_back(r);
        endfunction

        // compare a result word with the oldest expectation
        task check_result(input res_t got);
            res_t want_r;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result word with none pending: %h", got));
            end
            else
            begin
                want_r = expected_results.pop_front();
                if (got.value !== want_r.value)
                    report_mismatch($sformatf("value expected %h got %h",
                                              want_r.value, got.value));
                if (got.bits_done !== want_r.bits_done)
                    report_mismatch($sformatf("bits_done expected %0d got %0d",
                                              want_r.bits_done, got.bits_done));
                if (got.bits_remaining !== want_r.bits_remaining)
                    report_mismatch($sformatf("bits_remaining expected %0d got %0d",
                                              want_r.bits_remaining, got.bits_remaining));
                if (got.status !== want_r.status)
                    report_mismatch($sformatf("status expected %0d got %0d",
                                              want_r.status, got.status));
            end
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     opcode;
    logic [BYTE_W-1:0]   data_byte;
    logic [COUNT_W-1:0]  bit_count;
    logic                valid;
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  bits_done;
    logic [COUNT_W-1:0]  bits_remaining;
    logic [STATUS_W-1:0] status;

    bitstream_scoreboard sb;
    bit                  calm;
    int unsigned         words_sent;
    int unsigned         stall_cycles = 0;

    msb_first_bit_reader_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .data_byte      (data_byte),
        .bit_count      (bit_count),
        .valid          (valid),
        .value          (value),
        .bits_done      (bits_done),
        .bits_remaining (bits_remaining),
        .status         (status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // present one word, optionally after a random gap, and wait for it to be taken
    task automatic drive_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] din,
                              input logic [COUNT_W-1:0] count);
        if (!calm && $urandom_range(0, 99) < 24)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start     <= 1'b1;
        opcode    <= op;
        data_byte <= din;
        bit_count <= count;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
    endtask

    // monitor: results first, then the word taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (valid)
                sb.check_result({value, bits_done, bits_remaining, status});
            if (start && !busy)
                sb.predict_command(opcode, data_byte, bit_count);
        end
    end

    // watchdog on cycles with no progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || valid)
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int unsigned        pick;
        int unsigned        n;
        int unsigned        base;
        logic [COUNT_W-1:0] cnt;

        rst_n        <= 1'b0;
        start        <= 1'b0;
        opcode       <= OP_LOAD;
        data_byte    <= '0;
        bit_count    <= '0;
        calm         = 1'b0;
        words_sent   = 0;
        sb           = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty buffer, zero counts, byte crossings, saturation, running dry
        drive_word(OP_READ, 8'h00, 16'd8);
        drive_word(OP_SKIP, 8'hFF, 16'd0);
        drive_word(OP_READ, 8'h00, 16'd0);
        drive_word(OP_RESTART, 8'hFF, 16'hFFFF);
        drive_word(OP_LOAD, 8'h00, 16'hFFFF);
        drive_word(OP_LOAD, 8'hFF, 16'd0);
        drive_word(OP_LOAD, 8'hA5, 16'd0);
        drive_word(OP_LOAD, 8'h5A, 16'd0);
        drive_word(OP_READ, 8'h00, 16'd1);
        drive_word(OP_READ, 8'h00, 16'd7);
        drive_word(OP_READ, 8'h00, 16'd12);
        drive_word(OP_LOAD, 8'h80, 16'd0);
        drive_word(OP_LOAD, 8'h3C, 16'd0);
        drive_word(OP_LOAD, 8'hC3, 16'd0);
        drive_word(OP_LOAD, 8'h69, 16'd0);
        drive_word(OP_LOAD, 8'h96, 16'd0);
        drive_word(OP_READ, 8'h00, 16'd40);
        drive_word(OP_READ, 8'h00, 16'hFFFF);
        drive_word(OP_SKIP, 8'h00, 16'hFFFF);
        drive_word(OP_LOAD, 8'hFF, 16'd0);
        drive_word(OP_SKIP, 8'h00, 16'd3);
        drive_word(OP_SKIP, 8'h00, 16'd9);
        drive_word(OP_RESTART, 8'h00, 16'd0);
        drive_word(OP_LOAD, 8'h12, 16'd0);
        drive_word(OP_READ, 8'h00, 16'd32);

        // fill the store to the top, overflow it, then read out the far end
        drive_word(OP_RESTART, 8'h00, 16'd0);
        for (int i = 0; i < BUFFER_BYTES + 3; i++)
            drive_word(OP_LOAD, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        drive_word(OP_READ, 8'h00, 16'd5);
        drive_word(OP_READ, 8'h00, 16'd32);
        drive_word(OP_SKIP, 8'h00, 16'd30000);
        repeat (200)
            drive_word(OP_READ, 8'($urandom_range(0, 255)), 16'($urandom_range(1, 32)));
        drive_word(OP_SKIP, 8'h00, 16'hFFFF);
        drive_word(OP_RESTART, 8'h00, 16'd0);

        // random: mostly load bursts followed by reads and skips, some restarts and noise
        base = words_sent;
        while (words_sent < base + RANDOM_WORDS)
        begin
            calm = (words_sent - base >= 500) && (words_sent - base < 800);
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                    drive_word(OP_LOAD, 8'($urandom_range(0, 255)),
                               16'($urandom_range(0, 65535)));
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    if ($urandom_range(0, 7) == 0)
                        cnt = 16'($urandom_range(0, 65535));
                    else
                        cnt = 16'($urandom_range(0, 33));
                    drive_word(($urandom_range(0, 2) == 0) ? OP_SKIP : OP_READ,
                               8'($urandom_range(0, 255)), cnt);
                end
            end
            else if (pick < 80)
            begin
                drive_word(OP_RESTART, 8'($urandom_range(0, 255)),
                           16'($urandom_range(0, 65535)));
            end
            else
            begin
                drive_word(OP_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                           16'($urandom_range(0, 65535)));
            end
        end
        calm = 1'b0;
        start <= 1'b0;

        // drain the outstanding results, then let the pipeline settle
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
